/* rtl/bfsk_pkg.sv */
`timescale 1ns / 1ps
package bfsk_pkg;

	localparam int PHASE_BITS    = 24;
	localparam int MAX_FRAME     = 4096;
	localparam int FPOS_BITS     = $clog2(MAX_FRAME);
	localparam int FLEN_BITS     = FPOS_BITS + 1;
	localparam int CFG_DATA_BITS = (PHASE_BITS > FLEN_BITS) ? PHASE_BITS : FLEN_BITS;
	localparam int CFG_IDX_BITS  = 2;

	localparam int Q_FRAC    = 30;
	localparam int Q_BITS    = Q_FRAC + 1;
	localparam int PROD_BITS = 2 * Q_BITS;
	localparam int HI_BITS   = PROD_BITS - Q_FRAC;
	localparam int ZSHIFT    = 32 - PHASE_BITS;

	localparam int SAMPLE_BITS = 16;
	localparam int MAG_BITS    = SAMPLE_BITS - 1;

	localparam logic [Q_BITS-1:0] Q_ONE        = Q_BITS'(64'd1073741824);
	localparam logic [Q_BITS-1:0] COEF_A       = Q_BITS'(64'd1686629713);
	localparam logic [Q_BITS-1:0] COEF_B       = Q_BITS'(64'd688904866);
	localparam logic [Q_BITS-1:0] COEF_C       = Q_BITS'(64'd76016977);
	localparam logic [Q_BITS-1:0] SAMPLE_SCALE = Q_BITS'(64'd32767);
	localparam logic [MAG_BITS-1:0] MAG_MAX    = MAG_BITS'(32767);

	localparam logic [PHASE_BITS-1:0] PHASE_QUARTER = PHASE_BITS'(64'd1 << (PHASE_BITS - 2));

	localparam logic [FLEN_BITS-1:0]  FLEN_RESET  = FLEN_BITS'(1024);
	localparam logic [FLEN_BITS-1:0]  FLEN_MAX    = FLEN_BITS'(MAX_FRAME);
	localparam logic [PHASE_BITS-1:0] WSTEP_RESET = PHASE_BITS'(16384);

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_SPACE_STEP  = 2'd0,
		REG_MARK_STEP   = 2'd1,
		REG_FRAME_LEN   = 2'd2,
		REG_WINDOW_STEP = 2'd3
	} cfg_reg_e;

	typedef struct packed {
		logic [PHASE_BITS-1:0] space_phase_step;
		logic [PHASE_BITS-1:0] mark_phase_step;
		logic [FLEN_BITS-1:0]  frame_length;
		logic [PHASE_BITS-1:0] window_phase_step;
	} cfg_t;

	typedef struct packed {
		logic [PHASE_BITS-1:0] carrier_phase;
		logic [PHASE_BITS-1:0] window_phase;
		logic                  frame_last;
	} job_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_Z2_M,
		ST_Z2_W,
		ST_CZ_M,
		ST_CZ_W,
		ST_T1_M,
		ST_T1_W,
		ST_ZT_M,
		ST_ZT_W,
		ST_SW_M,
		ST_SW_W,
		ST_MK_M,
		ST_MK_W
	} back_state_t;

	function automatic logic [Q_BITS-1:0] phase_to_z(input logic [PHASE_BITS-1:0] ph);
		logic [PHASE_BITS-2:0] frac;
		frac = {1'b0, ph[PHASE_BITS-3:0]};
		if (ph[PHASE_BITS-2]) begin
			frac = PHASE_QUARTER[PHASE_BITS-2:0] - frac;
		end
		return Q_BITS'(frac) << ZSHIFT;
	endfunction

endpackage

/* rtl/bfsk_cfg.sv */
`timescale 1ns / 1ps
module bfsk_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [bfsk_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [bfsk_pkg::CFG_DATA_BITS-1:0] cfg_data,
	output bfsk_pkg::cfg_t                     cfg
);
	import bfsk_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.space_phase_step  <= '0;
			cfg_q.mark_phase_step   <= '0;
			cfg_q.frame_length      <= FLEN_RESET;
			cfg_q.window_phase_step <= WSTEP_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_reg_e'(cfg_index))
				REG_SPACE_STEP:  cfg_q.space_phase_step  <= cfg_data[PHASE_BITS-1:0];
				REG_MARK_STEP:   cfg_q.mark_phase_step   <= cfg_data[PHASE_BITS-1:0];
				REG_FRAME_LEN:   cfg_q.frame_length      <= cfg_data[FLEN_BITS-1:0];
				REG_WINDOW_STEP: cfg_q.window_phase_step <= cfg_data[PHASE_BITS-1:0];
				default: ;
			endcase
		end
	end

endmodule

/* rtl/bfsk_front.sv */
`timescale 1ns / 1ps
module bfsk_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic           tone_bit,
	input  logic           msg_start,
	input  bfsk_pkg::cfg_t cfg,
	input  logic           q_full,
	output logic           push,
	output bfsk_pkg::job_t push_job
);
	import bfsk_pkg::*;

	logic [PHASE_BITS-1:0] carrier_q;
	logic [PHASE_BITS-1:0] window_q;
	logic [FPOS_BITS-1:0]  fpos_q;
	logic                  held_q;

	logic [FLEN_BITS-1:0]  len_c;
	logic [PHASE_BITS-1:0] cp_c;
	logic [PHASE_BITS-1:0] wp_c;
	logic [PHASE_BITS-1:0] step_c;
	logic [FPOS_BITS-1:0]  fp_c;
	logic [FLEN_BITS-1:0]  fp_inc_c;
	logic                  ht_c;
	logic                  first_c;
	logic                  last_c;

	always_comb begin
		priority if (cfg.frame_length == '0) begin
			len_c = FLEN_BITS'(1);
		end else if (cfg.frame_length > FLEN_MAX) begin
			len_c = FLEN_MAX;
		end else begin
			len_c = cfg.frame_length;
		end
		cp_c     = msg_start ? '0 : carrier_q;
		fp_c     = msg_start ? '0 : fpos_q;
		first_c  = (fp_c == '0);
		ht_c     = first_c ? tone_bit : held_q;
		wp_c     = first_c ? '0 : window_q;
		step_c   = ht_c ? cfg.mark_phase_step : cfg.space_phase_step;
		fp_inc_c = {1'b0, fp_c} + FLEN_BITS'(1);
		last_c   = (fp_inc_c >= len_c);
	end

	assign in_ready = !q_full;
	assign push     = in_valid && !q_full;

	assign push_job.carrier_phase = cp_c;
	assign push_job.window_phase  = wp_c;
	assign push_job.frame_last    = last_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carrier_q <= '0;
			window_q  <= '0;
			fpos_q    <= '0;
			held_q    <= 1'b0;
		end else if (push) begin
			carrier_q <= cp_c + step_c;
			window_q  <= wp_c + cfg.window_phase_step;
			fpos_q    <= last_c ? '0 : fp_inc_c[FPOS_BITS-1:0];
			held_q    <= ht_c;
		end
	end

endmodule

/* rtl/bfsk_queue.sv */
`timescale 1ns / 1ps
module bfsk_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  bfsk_pkg::job_t push_job,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output bfsk_pkg::job_t head_job
);
	import bfsk_pkg::*;

	job_t                 slot_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q;
	logic [QPTR_BITS-1:0] rd_ptr_q;
	logic [QCNT_BITS-1:0] count_q;

	function automatic logic [QPTR_BITS-1:0] next_ptr(input logic [QPTR_BITS-1:0] p);
		return (p == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_BITS'(1);
	endfunction

	assign full       = (count_q == QCNT_BITS'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_job   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + QCNT_BITS'(1);
				2'b01:   count_q <= count_q - QCNT_BITS'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_BITS'(QUEUE_DEPTH))
		else $error("queue count above depth");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from empty queue");

endmodule

/* rtl/bfsk_back.sv */
`timescale 1ns / 1ps
module bfsk_back (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 head_valid,
	input  bfsk_pkg::job_t                       head_job,
	output logic                                 pop,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [bfsk_pkg::SAMPLE_BITS-1:0] sample,
	output logic                                 frame_last
);
	import bfsk_pkg::*;

	back_state_t state_q;
	back_state_t state_d;

	job_t                   job_q;
	logic [Q_BITS-1:0]      z_q;
	logic [Q_BITS-1:0]      z2_q;
	logic [Q_BITS-1:0]      t_q;
	logic [Q_BITS-1:0]      smag_q;
	logic [Q_BITS-1:0]      win_q;
	logic [Q_BITS-1:0]      m_q;
	logic                   sneg_q;
	logic                   cneg_q;
	logic                   pass_q;
	logic [PROD_BITS-1:0]   prod_q;

	logic                   out_valid_q;
	logic signed [SAMPLE_BITS-1:0] sample_q;
	logic                   frame_last_q;

	logic [Q_BITS-1:0]      op_a;
	logic [Q_BITS-1:0]      op_b;
	logic [HI_BITS-1:0]     prod_hi;
	logic [Q_BITS-1:0]      y_c;
	logic [Q_BITS:0]        win_sum_c;
	logic [PHASE_BITS-1:0]  cos_phase_c;
	logic [MAG_BITS-1:0]    mag_c;
	logic                   out_free;

	assign prod_hi     = prod_q[PROD_BITS-1:Q_FRAC];
	assign out_free    = !out_valid_q || out_ready;
	assign pop         = (state_q == ST_IDLE) && head_valid;
	assign cos_phase_c = job_q.window_phase + PHASE_QUARTER;

	assign out_valid  = out_valid_q;
	assign sample     = sample_q;
	assign frame_last = frame_last_q;

	always_comb begin
		y_c       = (prod_hi > HI_BITS'(Q_ONE)) ? Q_ONE : prod_hi[Q_BITS-1:0];
		win_sum_c = cneg_q ? ({1'b0, Q_ONE} + {1'b0, y_c}) : ({1'b0, Q_ONE} - {1'b0, y_c});
		mag_c     = (prod_hi > HI_BITS'(MAG_MAX)) ? MAG_MAX : prod_hi[MAG_BITS-1:0];
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (head_valid) state_d = ST_LOAD;
			ST_LOAD: state_d = ST_Z2_M;
			ST_Z2_M: state_d = ST_Z2_W;
			ST_Z2_W: state_d = ST_CZ_M;
			ST_CZ_M: state_d = ST_CZ_W;
			ST_CZ_W: state_d = ST_T1_M;
			ST_T1_M: state_d = ST_T1_W;
			ST_T1_W: state_d = ST_ZT_M;
			ST_ZT_M: state_d = ST_ZT_W;
			ST_ZT_W: state_d = pass_q ? ST_SW_M : ST_Z2_M;
			ST_SW_M: state_d = ST_SW_W;
			ST_SW_W: state_d = ST_MK_M;
			ST_MK_M: state_d = ST_MK_W;
			ST_MK_W: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		op_a = '0;
		op_b = '0;
		unique case (state_q)
			ST_Z2_M: begin
				op_a = z_q;
				op_b = z_q;
			end
			ST_CZ_M: begin
				op_a = COEF_C;
				op_b = z2_q;
			end
			ST_T1_M: begin
				op_a = z2_q;
				op_b = t_q;
			end
			ST_ZT_M: begin
				op_a = z_q;
				op_b = t_q;
			end
			ST_SW_M: begin
				op_a = smag_q;
				op_b = win_q;
			end
			ST_MK_M, ST_MK_W: begin
				op_a = m_q;
				op_b = SAMPLE_SCALE;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= PROD_BITS'(op_a) * PROD_BITS'(op_b);
		unique case (state_q)
			ST_IDLE: begin
				if (head_valid) begin
					job_q  <= head_job;
					pass_q <= 1'b0;
				end
			end
			ST_LOAD: begin
				z_q    <= phase_to_z(job_q.carrier_phase);
				sneg_q <= job_q.carrier_phase[PHASE_BITS-1];
			end
			ST_Z2_W: z2_q <= prod_hi[Q_BITS-1:0];
			ST_CZ_W: t_q  <= COEF_B - prod_hi[Q_BITS-1:0];
			ST_T1_W: t_q  <= COEF_A - prod_hi[Q_BITS-1:0];
			ST_ZT_W: begin
				if (!pass_q) begin
					smag_q <= y_c;
					z_q    <= phase_to_z(cos_phase_c);
					cneg_q <= cos_phase_c[PHASE_BITS-1];
					pass_q <= 1'b1;
				end else begin
					win_q <= win_sum_c[Q_BITS:1];
				end
			end
			ST_SW_W: m_q <= prod_hi[Q_BITS-1:0];
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_MK_W && out_free) begin
			sample_q     <= sneg_q ? -$signed({1'b0, mag_c}) : $signed({1'b0, mag_c});
			frame_last_q <= job_q.frame_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_MK_W && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	a_sample_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (sample != -16'sd32768))
		else $error("sample outside symmetric range");

	a_pop_starts: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (state_q == ST_LOAD))
		else $error("pop did not start a job");

	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !pop)
		else $error("pop while busy");

endmodule

/* rtl/bfsk_windowed_tone_generator_top.sv */
`timescale 1ns / 1ps
// Binary FSK tone generator with a raised-cosine window, one 16-bit sample per
// input transfer. The front end advances carrier phase, window phase and frame
// position at the moment a transfer is taken and queues the two phases and the
// end-of-frame flag; up to two items wait in the queue while the back end works.
// The back end evaluates both sines and the scaling on one shared 31x31
// multiplier, each multiply having a multiply state and a writeback state. The
// back end pops an item only when idle and takes the next one only after the
// output register has taken the previous sample. The output register holds a
// finished sample while the next one is computed. Configuration writes are
// always taken and should only be made while the block is idle.
module bfsk_windowed_tone_generator_top (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     cfg_valid,
	output logic                                     cfg_ready,
	input  logic [bfsk_pkg::CFG_IDX_BITS-1:0]        cfg_index,
	input  logic [bfsk_pkg::CFG_DATA_BITS-1:0]       cfg_data,
	input  logic                                     in_valid,
	output logic                                     in_ready,
	input  logic                                     tone_bit,
	input  logic                                     msg_start,
	output logic                                     out_valid,
	input  logic                                     out_ready,
	output logic signed [bfsk_pkg::SAMPLE_BITS-1:0]  sample,
	output logic                                     frame_last
);
	import bfsk_pkg::*;

	cfg_t cfg;
	job_t push_job;
	job_t head_job;
	logic push;
	logic pop;
	logic q_full;
	logic head_valid;

	bfsk_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	bfsk_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.tone_bit  (tone_bit),
		.msg_start (msg_start),
		.cfg       (cfg),
		.q_full    (q_full),
		.push      (push),
		.push_job  (push_job)
	);

	bfsk_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	bfsk_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.sample     (sample),
		.frame_last (frame_last)
	);

endmodule
